[hdl/mpm_pkg.sv]
// Shared types, constants and helpers of the Mandelbrot pixel membership unit.
package mpm_pkg;

  localparam int COORD_BITS = 12;
  localparam int DEF_FRACTION_BITS = 28;
  localparam int DEF_ITER_BITS = 16;

  localparam int WORD_W = 32;
  localparam int PROD_W = 2 * WORD_W;
  localparam int DIM_W = 13;
  localparam int SCALE_W = 29;
  localparam int MAXIT_W = 16;
  localparam int COLOR_W = 24;
  localparam int APB_DW = 32;
  localparam int ADDR_W = 5;

  // Signed difference (index - size/2) and its product with an unsigned scale.
  localparam int DIFF_W = ((COORD_BITS > DIM_W - 1) ? COORD_BITS : DIM_W - 1) + 2;
  localparam int MAP_W = DIFF_W + SCALE_W + 1;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW = $clog2(Q_DEPTH);

  localparam logic [COLOR_W-1:0] WHITE_COLOR = {COLOR_W{1'b1}};

  localparam logic [DIM_W-1:0]   RST_WIDTH = DIM_W'(512);
  localparam logic [DIM_W-1:0]   RST_HEIGHT = DIM_W'(512);
  localparam logic [SCALE_W-1:0] RST_SCALE = SCALE_W'(1342177);
  localparam logic [MAXIT_W-1:0] RST_MAX_ITER = MAXIT_W'(256);
  localparam logic [COLOR_W-1:0] RST_BG = '0;

  typedef enum logic [2:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_SCALE_X  = 3'd2,
    REG_SCALE_Y  = 3'd3,
    REG_MAX_ITER = 3'd4,
    REG_BG_COLOR = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_CHK,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
  } pixel_t;

  typedef struct packed {
    logic               in_set;
    logic [COLOR_W-1:0] pixel_color;
  } result_t;

  typedef struct packed {
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
    logic [MAXIT_W-1:0] max_iterations;
    logic [COLOR_W-1:0] background_color;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] c_real;
    logic [WORD_W-1:0] c_imag;
  } point_t;

  // Clamp a wide signed value to the signed 32-bit word range.
  function automatic logic [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end else if (v < 64'shFFFF_FFFF_8000_0000) begin
      return 32'h8000_0000;
    end else begin
      return v[WORD_W-1:0];
    end
  endfunction

endpackage

[hdl/mpm_regs.sv]
// Configuration register file behind the APB-style port.
module mpm_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mpm_pkg::ADDR_W-1:0] paddr,
  input  logic [mpm_pkg::APB_DW-1:0] pwdata,
  output logic [mpm_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output mpm_pkg::cfg_t             cfg_o
);
  import mpm_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_WIDTH:    cfg_d.image_width      = pwdata[DIM_W-1:0];
        REG_HEIGHT:   cfg_d.image_height     = pwdata[DIM_W-1:0];
        REG_SCALE_X:  cfg_d.scale_x          = pwdata[SCALE_W-1:0];
        REG_SCALE_Y:  cfg_d.scale_y          = pwdata[SCALE_W-1:0];
        REG_MAX_ITER: cfg_d.max_iterations   = pwdata[MAXIT_W-1:0];
        REG_BG_COLOR: cfg_d.background_color = pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:    prdata = APB_DW'(cfg_q.image_width);
      REG_HEIGHT:   prdata = APB_DW'(cfg_q.image_height);
      REG_SCALE_X:  prdata = APB_DW'(cfg_q.scale_x);
      REG_SCALE_Y:  prdata = APB_DW'(cfg_q.scale_y);
      REG_MAX_ITER: prdata = APB_DW'(cfg_q.max_iterations);
      REG_BG_COLOR: prdata = APB_DW'(cfg_q.background_color);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width      <= RST_WIDTH;
      cfg_q.image_height     <= RST_HEIGHT;
      cfg_q.scale_x          <= RST_SCALE;
      cfg_q.scale_y          <= RST_SCALE;
      cfg_q.max_iterations   <= RST_MAX_ITER;
      cfg_q.background_color <= RST_BG;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[hdl/mpm_front.sv]
// Front end: accepts pixels and maps them to the complex point c.
module mpm_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  mpm_pkg::pixel_t  item_i,
  output logic             full,
  input  mpm_pkg::cfg_t    cfg_i,
  output logic             pt_valid_o,
  output mpm_pkg::point_t  pt_o,
  input  logic             pt_ready_i
);
  import mpm_pkg::*;

  pixel_t                   item_q;
  logic                     s1_valid_q, s1_valid_d;
  logic                     s2_valid_q, s2_valid_d;
  logic                     s1_adv, s2_adv, accept;
  logic signed [DIFF_W-1:0] diff_re, diff_im;
  logic signed [MAP_W-1:0]  prod_re, prod_im;
  logic signed [MAP_W-1:0]  prod_re_q, prod_im_q;

  assign s2_adv = s2_valid_q && pt_ready_i;
  assign s1_adv = s1_valid_q && (!s2_valid_q || s2_adv);
  assign full   = s1_valid_q && !s1_adv;
  assign accept = push && !full;

  assign s1_valid_d = accept || (s1_valid_q && !s1_adv);
  assign s2_valid_d = s1_adv || (s2_valid_q && !s2_adv);

  // Offset from the image center, then scale.
  assign diff_re = $signed(DIFF_W'(item_q.column)) - $signed(DIFF_W'(cfg_i.image_width >> 1));
  assign diff_im = $signed(DIFF_W'(item_q.row)) - $signed(DIFF_W'(cfg_i.image_height >> 1));
  assign prod_re = diff_re * $signed({1'b0, cfg_i.scale_x});
  assign prod_im = diff_im * $signed({1'b0, cfg_i.scale_y});

  assign pt_valid_o  = s2_valid_q;
  assign pt_o.c_real = sat_word(PROD_W'(prod_re_q));
  assign pt_o.c_imag = sat_word(PROD_W'(prod_im_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    if (s1_adv) begin
      prod_re_q <= prod_re;
      prod_im_q <= prod_im;
    end
  end

endmodule

[hdl/mpm_queue.sv]
// Short queue of mapped points between the front and the back end.
module mpm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  input  mpm_pkg::point_t wr_data_i,
  output logic            wr_ready_o,
  output logic            rd_valid_o,
  output mpm_pkg::point_t rd_data_o,
  input  logic            rd_i
);
  import mpm_pkg::*;

  point_t          mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_AW:0]   count_q, count_d;
  logic            wr_en, rd_en;

  assign wr_ready_o = (count_q != Q_DEPTH[Q_AW:0]);
  assign rd_valid_o = (count_q != '0);
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_i && rd_valid_o;
  assign rd_data_o  = mem[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (wr_en && !rd_en) begin
      count_d = count_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_ptr_q] <= wr_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Q_DEPTH[Q_AW:0])
    else $error("point queue holds more items than its depth");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == Q_DEPTH[Q_AW:0]) |-> (wr_ptr_q == rd_ptr_q))
    else $error("point queue pointers disagree with its fill count");

endmodule

[hdl/mpm_back.sv]
// Back end: escape-time iteration of z = z*z + c and the result register.
module mpm_back #(
  parameter int FRACTION_BITS = mpm_pkg::DEF_FRACTION_BITS,
  parameter int ITER_BITS     = mpm_pkg::DEF_ITER_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mpm_pkg::cfg_t    cfg_i,
  input  logic             pt_valid_i,
  input  mpm_pkg::point_t  pt_i,
  output logic             pt_pop_o,
  output logic             empty,
  output mpm_pkg::result_t result_o,
  input  logic             pop
);
  import mpm_pkg::*;

  localparam int ESC_SH = 2 * FRACTION_BITS + 2;
  localparam logic [PROD_W-1:0] ESC_LIM =
    (ESC_SH >= PROD_W) ? {PROD_W{1'b1}} : (PROD_W'(1) << ESC_SH);

  back_state_e              state_q, state_d;
  logic                     out_valid_q, out_valid_d;
  logic                     load_c, load_prod, step_z, finish, emit;
  logic                     inside_q;
  result_t                  out_q;
  logic [WORD_W-1:0]        z_re_q, z_im_q, c_re_q, c_im_q;
  logic [ITER_BITS-1:0]     cnt_q, limit;
  logic [2*MAXIT_W-1:0]     max_ext;
  logic signed [PROD_W-1:0] rr, ii, ri;
  logic signed [PROD_W-1:0] rr_q, ii_q, ri_q;
  logic signed [PROD_W-1:0] rr_minus_ii, nr, ni;
  logic [PROD_W-1:0]        mag;
  logic                     escaped, lim_hit, pop_fire;

  assign max_ext = (2*MAXIT_W)'(cfg_i.max_iterations);
  assign limit   = max_ext[ITER_BITS-1:0];

  assign rr = $signed(z_re_q) * $signed(z_re_q);
  assign ii = $signed(z_im_q) * $signed(z_im_q);
  assign ri = $signed(z_re_q) * $signed(z_im_q);

  assign mag         = rr_q + ii_q;
  assign escaped     = mag > ESC_LIM;
  assign lim_hit     = cnt_q >= limit;
  assign rr_minus_ii = rr_q - ii_q;
  assign nr = (rr_minus_ii >>> FRACTION_BITS) + PROD_W'($signed(c_re_q));
  assign ni = (ri_q >>> (FRACTION_BITS - 1)) + PROD_W'($signed(c_im_q));

  assign pop_fire = pop && out_valid_q;
  assign empty    = !out_valid_q;
  assign result_o = out_q;

  always_comb begin
    state_d   = state_q;
    pt_pop_o  = 1'b0;
    load_c    = 1'b0;
    load_prod = 1'b0;
    step_z    = 1'b0;
    finish    = 1'b0;
    emit      = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (pt_valid_i) begin
          pt_pop_o = 1'b1;
          load_c   = 1'b1;
          state_d  = BK_MUL;
        end
      end
      BK_MUL: begin
        load_prod = 1'b1;
        state_d   = BK_CHK;
      end
      BK_CHK: begin
        if (escaped || lim_hit) begin
          finish  = 1'b1;
          state_d = BK_DONE;
        end else begin
          step_z  = 1'b1;
          state_d = BK_MUL;
        end
      end
      BK_DONE: begin
        // Hold the result until the output slot frees up.
        if (!out_valid_q || pop_fire) begin
          emit    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !pop_fire;
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_c) begin
      c_re_q <= pt_i.c_real;
      c_im_q <= pt_i.c_imag;
      z_re_q <= '0;
      z_im_q <= '0;
      cnt_q  <= '0;
    end
    if (load_prod) begin
      rr_q <= rr;
      ii_q <= ii;
      ri_q <= ri;
    end
    if (step_z) begin
      z_re_q <= sat_word(nr);
      z_im_q <= sat_word(ni);
      cnt_q  <= cnt_q + 1'b1;
    end
    if (finish) begin
      inside_q <= (cnt_q == limit);
    end
    if (emit) begin
      out_q.in_set      <= inside_q;
      out_q.pixel_color <= inside_q ? WHITE_COLOR : cfg_i.background_color;
    end
  end

  a_chk_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_CHK) |-> ($past(state_q) == BK_MUL))
    else $error("escape check without fresh products");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_CHK) |-> (cnt_q <= limit))
    else $error("iteration count ran past the limit");

endmodule

[hdl/mandelbrot_pixel_membership_unit.sv]
// Top level of the Mandelbrot pixel membership unit.
// Usage: write pixels (column, row) into the input queue with push while full is low.
// Each pixel maps to c in signed Q4.28 (by default) from the image size and scale
// registers, then z = z*z + c runs from zero until |z|^2 exceeds 4 or the count
// reaches max_iterations. The result item (in_set, pixel_color) appears on result_o
// while empty is low and leaves on pop.
// Each iteration has two steps: a multiply state registers the three 32x32 products,
// then a check state does the escape check and z update. Pixels are iterated one at
// a time; a two-entry point queue lets the front map the next pixels meanwhile.
// A finished result waits in an output register; while the receiver holds pop low
// the back end stalls once its next result is done, the queue fills and full rises.
// Reset empties the pipeline and restores the register defaults (512 x 512 image,
// scale 1342177, 256 iterations, black background). Write registers only while idle.
module mandelbrot_pixel_membership_unit #(
  parameter int FRACTION_BITS = mpm_pkg::DEF_FRACTION_BITS,
  parameter int ITER_BITS     = mpm_pkg::DEF_ITER_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  input  mpm_pkg::pixel_t            item_i,
  output logic                       full,
  output logic                       empty,
  output mpm_pkg::result_t           result_o,
  input  logic                       pop,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mpm_pkg::ADDR_W-1:0] paddr,
  input  logic [mpm_pkg::APB_DW-1:0] pwdata,
  output logic [mpm_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import mpm_pkg::*;

  cfg_t   cfg;
  point_t fr_pt, q_pt;
  logic   fr_valid, q_ready, q_valid, q_pop;

  mpm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mpm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .item_i     (item_i),
    .full       (full),
    .cfg_i      (cfg),
    .pt_valid_o (fr_valid),
    .pt_o       (fr_pt),
    .pt_ready_i (q_ready)
  );

  mpm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_data_i  (fr_pt),
    .wr_ready_o (q_ready),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_pt),
    .rd_i       (q_pop)
  );

  mpm_back #(
    .FRACTION_BITS (FRACTION_BITS),
    .ITER_BITS     (ITER_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .pt_valid_i (q_valid),
    .pt_i       (q_pt),
    .pt_pop_o   (q_pop),
    .empty      (empty),
    .result_o   (result_o),
    .pop        (pop)
  );

endmodule
